/* src/code_length_run_encoder_core_assert.svh */
// Assertion macros shared by the code length run encoder RTL.
`ifndef CODE_LENGTH_RUN_ENCODER_CORE_ASSERT_SVH
`define CODE_LENGTH_RUN_ENCODER_CORE_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CLRE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CLRE_ASSERT(label, prop, msg) \
  `CLRE_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* src/clre_pkg.sv */
// Package with constants and widths of the code length run encoder.
`timescale 1ns / 1ps
`default_nettype none

package clre_pkg;

  localparam int unsigned MAX_SYMBOLS = 316;
  localparam int unsigned MAX_RESULTS = 55;

  localparam int unsigned LEN_W      = 4;
  localparam int unsigned SYM_W      = 5;
  localparam int unsigned REP_W      = 8;
  localparam int unsigned RES_CNT_W  = 6;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [SYM_W-1:0] SYM_REPEAT_PREV = 5'd16;
  localparam logic [SYM_W-1:0] SYM_ZERO_SHORT  = 5'd17;
  localparam logic [SYM_W-1:0] SYM_ZERO_LONG   = 5'd18;
  localparam logic [SYM_W-1:0] SYM_ZERO_LIT    = 5'd0;

  localparam int unsigned ZERO_SHORT_MAX = 10;
  localparam int unsigned ZERO_LONG_MAX  = 138;
  localparam int unsigned REPEAT_MAX     = 6;
  localparam int unsigned LITERAL_MAX    = 2;

endpackage

`default_nettype wire

/* src/code_length_run_encoder_core.sv */
// Code length run encoder: run tracking and iterative deflate symbol flush.
// An item that only opens or extends a run is taken while the block stays
// ready. An item that closes a run moves the block to the flush state, which
// loads one result per cycle into the output register (up to 55) while that
// register is empty or being taken; output back-pressure holds the flush.
// Ready returns with the load of the final result of the item.
// Reset (rst_ni low, asynchronous) closes any open run and drops pending output.
`timescale 1ns / 1ps
`default_nettype none

module code_length_run_encoder_core #(
  parameter int unsigned MaxSymbols = clre_pkg::MAX_SYMBOLS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [3:0] code_length, [7:4] zero
  input  wire logic [clre_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // is_last
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [4:0] symbol, [12:5] repeat_count, [15:13] zero
  output logic [clre_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // last_of_item
  output logic                                    m_axis_tlast,
  // end_of_sequence
  output logic                                    m_axis_tuser
);

`include "code_length_run_encoder_core_assert.svh"

  localparam int unsigned RunW = $clog2(MaxSymbols + 1);
  localparam int unsigned CmpW = (RunW > clre_pkg::REP_W) ? RunW : clre_pkg::REP_W;
  localparam int unsigned LenW = clre_pkg::LEN_W;
  localparam int unsigned SymW = clre_pkg::SYM_W;
  localparam int unsigned RepW = clre_pkg::REP_W;
  localparam int unsigned ResW = clre_pkg::RES_CNT_W;
  localparam int unsigned PadW = clre_pkg::OUT_TDATA_W - SymW - RepW;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e            state_q, state_d;

  // Run tracking
  logic [LenW-1:0]   prev_q, prev_d;
  logic              run_valid_q, run_valid_d;
  logic [RunW-1:0]   run_cnt_q, run_cnt_d;

  // Flush sequencer
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   len2_q, len2_d;
  logic [RunW-1:0]   rest_q, rest_d;
  logic              first_q, first_d;
  logic              pend_q, pend_d;
  logic              seq_last_q, seq_last_d;
  logic [ResW-1:0]   res_cnt_q, res_cnt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [SymW-1:0]   out_sym_q;
  logic [RepW-1:0]   out_rep_q;
  logic              out_lst_q;
  logic              out_eos_q;

  logic [LenW-1:0]   in_len;
  logic              in_acc;
  logic              match;
  logic [RunW-1:0]   cnt_inc;
  logic [LenW-1:0]   new_prev;
  logic [RunW-1:0]   new_cnt;
  logic              adv;

  // Shared step unit
  logic [CmpW-1:0]   r_ext;
  logic [CmpW-1:0]   dec;
  logic [CmpW-1:0]   r_next;
  logic [SymW-1:0]   step_sym;
  logic [RepW-1:0]   step_rep;
  logic              step_final;

  assign in_len        = s_axis_tdata[LenW-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign adv           = (state_q == ST_FLUSH) && (!out_valid_q || m_axis_tready);

  assign match   = run_valid_q && (in_len == prev_q);
  assign cnt_inc = (run_cnt_q < RunW'(MaxSymbols)) ? run_cnt_q + 1'b1 : run_cnt_q;
  assign new_prev = match ? prev_q : in_len;
  assign new_cnt  = match ? cnt_inc : RunW'(1);

  // Pick symbol and decrement, then one subtract produces the remaining count
  always_comb begin
    r_ext    = CmpW'(rest_q);
    step_sym = SymW'(len_q);
    step_rep = RepW'(1);
    dec      = CmpW'(1);
    if (len_q == '0) begin
      if (r_ext <= CmpW'(clre_pkg::LITERAL_MAX)) begin
        step_sym = clre_pkg::SYM_ZERO_LIT;
      end else if (r_ext <= CmpW'(clre_pkg::ZERO_SHORT_MAX)) begin
        step_sym = clre_pkg::SYM_ZERO_SHORT;
        step_rep = RepW'(r_ext);
        dec      = r_ext;
      end else if (r_ext <= CmpW'(clre_pkg::ZERO_LONG_MAX)) begin
        step_sym = clre_pkg::SYM_ZERO_LONG;
        step_rep = RepW'(r_ext);
        dec      = r_ext;
      end else begin
        step_sym = clre_pkg::SYM_ZERO_LONG;
        step_rep = RepW'(clre_pkg::ZERO_LONG_MAX);
        dec      = CmpW'(clre_pkg::ZERO_LONG_MAX);
      end
    end else if (!first_q && (r_ext > CmpW'(clre_pkg::LITERAL_MAX))) begin
      step_sym = clre_pkg::SYM_REPEAT_PREV;
      if (r_ext <= CmpW'(clre_pkg::REPEAT_MAX)) begin
        step_rep = RepW'(r_ext);
        dec      = r_ext;
      end else begin
        step_rep = RepW'(clre_pkg::REPEAT_MAX);
        dec      = CmpW'(clre_pkg::REPEAT_MAX);
      end
    end
    r_next     = r_ext - dec;
    step_final = ((r_next == '0) && !pend_q) ||
                 (res_cnt_q == ResW'(clre_pkg::MAX_RESULTS - 1));
  end

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    run_valid_d = run_valid_q;
    run_cnt_d   = run_cnt_q;
    len_d       = len_q;
    len2_d      = len2_q;
    rest_d      = rest_q;
    first_d     = first_q;
    pend_d      = pend_q;
    seq_last_d  = seq_last_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tlast) begin
            prev_d      = '0;
            run_valid_d = 1'b0;
            run_cnt_d   = '0;
          end else begin
            prev_d      = new_prev;
            run_valid_d = 1'b1;
            run_cnt_d   = new_cnt;
          end
          len2_d     = in_len;
          first_d    = 1'b1;
          seq_last_d = s_axis_tlast;
          res_cnt_d  = '0;
          if (run_valid_q && !match) begin
            // close the old run; the new one follows if this is the last item
            len_d   = prev_q;
            rest_d  = run_cnt_q;
            pend_d  = s_axis_tlast;
            state_d = ST_FLUSH;
          end else if (s_axis_tlast) begin
            len_d   = new_prev;
            rest_d  = new_cnt;
            pend_d  = 1'b0;
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          out_valid_d = 1'b1;
          res_cnt_d   = res_cnt_q + 1'b1;
          if (step_final) begin
            state_d = ST_IDLE;
          end else if (r_next == '0) begin
            len_d   = len2_q;
            rest_d  = RunW'(1);
            first_d = 1'b1;
            pend_d  = 1'b0;
          end else begin
            rest_d  = RunW'(r_next);
            first_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      run_valid_q <= 1'b0;
      run_cnt_q   <= '0;
      len_q       <= '0;
      len2_q      <= '0;
      rest_q      <= '0;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      seq_last_q  <= 1'b0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      run_valid_q <= run_valid_d;
      run_cnt_q   <= run_cnt_d;
      len_q       <= len_d;
      len2_q      <= len2_d;
      rest_q      <= rest_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      seq_last_q  <= seq_last_d;
      res_cnt_q   <= res_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload holds until the next advance
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sym_q <= step_sym;
      out_rep_q <= step_rep;
      out_lst_q <= step_final;
      out_eos_q <= step_final && seq_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PadW'(0), out_rep_q, out_sym_q};
  assign m_axis_tlast  = out_lst_q;
  assign m_axis_tuser  = out_eos_q;

  `CLRE_ASSERT(a_eos_is_item_end, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "end of sequence without item end")
  `CLRE_ASSERT(a_rep_range, m_axis_tvalid |-> ((out_rep_q != '0) && (out_rep_q <= RepW'(clre_pkg::ZERO_LONG_MAX))), "repeat count out of range")
  `CLRE_ASSERT(a_literal_rep_one, (m_axis_tvalid && (out_sym_q < clre_pkg::SYM_REPEAT_PREV)) |-> (out_rep_q == RepW'(1)), "literal with repeat above one")
  `CLRE_ASSERT(a_res_cnt_max, res_cnt_q <= ResW'(clre_pkg::MAX_RESULTS), "result count above limit")
  `CLRE_ASSERT(a_run_cnt_max, run_cnt_q <= RunW'(MaxSymbols), "run count above saturation")
  `CLRE_ASSERT(a_flush_rest_nonzero, (state_q == ST_FLUSH) |-> (rest_q != '0), "flush with empty run")

endmodule

`default_nettype wire

/* bench/clre_run_checker.sv */
`timescale 1ns / 1ps
// Checker for the code length run encoder: predicts the symbol stream and compares results.
module clre_run_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_tvalid_i,
  input  wire logic                                 s_tready_i,
  input  wire logic [clre_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  wire logic                                 s_tlast_i,
  input  wire logic                                 m_tvalid_i,
  input  wire logic                                 m_tready_i,
  input  wire logic [clre_pkg::OUT_TDATA_W-1:0]     m_tdata_i,
  input  wire logic                                 m_tlast_i,
  input  wire logic                                 m_tuser_i,
  output int                                        fail_count_o,
  output int                                        pending_o
);

  typedef struct packed {
    logic [clre_pkg::SYM_W-1:0] sym;
    logic [clre_pkg::REP_W-1:0] rep;
    logic                       item_end;
    logic                       seq_end;
  } cl_symbol_t;

  cl_symbol_t                  expected_q[$];
  logic [clre_pkg::LEN_W-1:0]  held_len;
  logic                        run_open;
  int unsigned                 run_len;

  // Drop anything beyond the per-transaction result cap.
  task automatic emit_symbol(input logic [clre_pkg::SYM_W-1:0] sym, input int unsigned rep,
                             ref cl_symbol_t batch[$]);
    cl_symbol_t s;
    s.sym      = sym;
    s.rep      = rep[clre_pkg::REP_W-1:0];
    s.item_end = 1'b0;
    s.seq_end  = 1'b0;
    if (batch.size() < clre_pkg::MAX_RESULTS) batch.push_back(s);
  endtask

  task automatic encode_run(input logic [clre_pkg::LEN_W-1:0] len, input int unsigned count,
                            ref cl_symbol_t batch[$]);
    int unsigned rest;
    rest = count;
    if (count != 0 && len == '0) begin
      while (rest > 0) begin
        if (rest <= clre_pkg::LITERAL_MAX) begin
          emit_symbol(clre_pkg::SYM_ZERO_LIT, 1, batch);
          rest--;
        end else if (rest <= clre_pkg::ZERO_SHORT_MAX) begin
          emit_symbol(clre_pkg::SYM_ZERO_SHORT, rest, batch);
          rest = 0;
        end else if (rest <= clre_pkg::ZERO_LONG_MAX) begin
          emit_symbol(clre_pkg::SYM_ZERO_LONG, rest, batch);
          rest = 0;
        end else begin
          emit_symbol(clre_pkg::SYM_ZERO_LONG, clre_pkg::ZERO_LONG_MAX, batch);
          rest -= clre_pkg::ZERO_LONG_MAX;
        end
      end
    end else if (count != 0) begin
      // One plain literal first, then repeats of the previous length.
      emit_symbol({1'b0, len}, 1, batch);
      rest = count - 1;
      while (rest > 0) begin
        if (rest <= clre_pkg::LITERAL_MAX) begin
          emit_symbol({1'b0, len}, 1, batch);
          rest--;
        end else if (rest <= clre_pkg::REPEAT_MAX) begin
          emit_symbol(clre_pkg::SYM_REPEAT_PREV, rest, batch);
          rest = 0;
        end else begin
          emit_symbol(clre_pkg::SYM_REPEAT_PREV, clre_pkg::REPEAT_MAX, batch);
          rest -= clre_pkg::REPEAT_MAX;
        end
      end
    end
  endtask

  task automatic predict_symbols(input logic [clre_pkg::LEN_W-1:0] len, input logic last);
    cl_symbol_t batch[$];
    if (run_open && len == held_len) begin
      // Saturate an overlong run.
      if (run_len < clre_pkg::MAX_SYMBOLS) run_len++;
    end else begin
      if (run_open) encode_run(held_len, run_len, batch);
      held_len = len;
      run_len  = 1;
      run_open = 1'b1;
    end
    if (last) begin
      encode_run(held_len, run_len, batch);
      held_len = '0;
      run_len  = 0;
      run_open = 1'b0;
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].item_end = 1'b1;
      batch[batch.size()-1].seq_end  = last;
    end
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endtask

  task automatic compare_symbol();
    cl_symbol_t got;
    cl_symbol_t want;
    got.sym      = m_tdata_i[clre_pkg::SYM_W-1:0];
    got.rep      = m_tdata_i[clre_pkg::SYM_W +: clre_pkg::REP_W];
    got.item_end = m_tlast_i;
    got.seq_end  = m_tuser_i;
    if (expected_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected transaction sym=%0d rep=%0d tlast=%b tuser=%b",
                 $realtime, got.sym, got.rep, got.item_end, got.seq_end);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("%0t: expected sym=%0d rep=%0d tlast=%b tuser=%b, got sym=%0d rep=%0d tlast=%b tuser=%b",
                   $realtime, want.sym, want.rep, want.item_end, want.seq_end,
                   got.sym, got.rep, got.item_end, got.seq_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_len = '0;
      run_len  = 0;
      run_open = 1'b0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        predict_symbols(s_tdata_i[clre_pkg::LEN_W-1:0], s_tlast_i);
      if (m_tvalid_i && m_tready_i) compare_symbol();
      pending_o = expected_q.size();
    end
  end

endmodule

/* bench/tb_code_length_run_encoder_core.sv */
`timescale 1ns / 1ps
// Top of the code length run encoder bench: clock, reset, traffic and verdict.
module tb_code_length_run_encoder_core;

  localparam int unsigned NumRandomItems = 110;
  localparam int unsigned PauseEvery     = 30;
  localparam int unsigned MaxWait        = 18;
  localparam int unsigned LongHold       = 240;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned TailCycles     = 80;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [clre_pkg::IN_TDATA_W-1:0]     s_tdata;
  logic                                s_tlast;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [clre_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic                                m_tlast;
  logic                                m_tuser;

  int fail_count;
  int pending;
  int items_sent;
  int src_calm;
  int snk_calm;
  bit hold_req;

  code_length_run_encoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  clre_run_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly random waits, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  task automatic send_length(input logic [clre_pkg::LEN_W-1:0] len, input logic last);
    int gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= clre_pkg::IN_TDATA_W'(len);
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_run(input logic [clre_pkg::LEN_W-1:0] len, input int count,
                          input logic close);
    for (int i = 0; i < count; i++) send_length(len, close && (i == count - 1));
  endtask

  // Hold off new transactions until every predicted symbol has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_code_table();
    int runs;
    int pick;
    int count;
    logic [clre_pkg::LEN_W-1:0] len;
    runs = $urandom_range(1, 8);
    for (int r = 0; r < runs; r++) begin
      len  = ($urandom_range(0, 9) < 4) ? '0 : clre_pkg::LEN_W'($urandom_range(1, 15));
      pick = $urandom_range(0, 19);
      if (pick < 11)      count = $urandom_range(1, 4);
      else if (pick < 17) count = $urandom_range(5, 14);
      else if (pick < 19) count = $urandom_range(15, 40);
      else                count = $urandom_range(100, 150);
      send_run(len, count, r == runs - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_length(clre_pkg::LEN_W'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : sink
    int gap;
    m_tready = 1'b0;
    snk_calm = 0;
    hold_req = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      gap = draw_wait(snk_calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Abort when neither side moves a transaction for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("[code_length_run_encoder_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    int next_pause;
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    src_calm   = 0;
    items_sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short tables: single literals, short zero runs, repeats of a non-zero length.
    send_run(4'd15, 1, 1'b1);
    send_run(4'd0, 1, 1'b1);
    send_run(4'd0, 2, 1'b0);
    send_run(4'd7, 1, 1'b1);
    send_run(4'd0, 3, 1'b0);
    send_run(4'd5, 2, 1'b1);
    send_run(4'd4, 4, 1'b1);
    send_run(4'd9, 7, 1'b0);
    send_run(4'd8, 3, 1'b1);
    wait_drained();

    // Long zero code, then a saturated run whose flush fills the result cap.
    send_run(4'd0, 11, 1'b0);
    send_run(4'd1, 1, 1'b1);
    send_run(4'd12, 317, 1'b0);
    send_run(4'd6, 1, 1'b1);
    wait_drained();

    items_sent = 0;
    next_pause = PauseEvery;
    while (items_sent < NumRandomItems) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_code_table();
      if (items_sent >= next_pause) begin
        if (next_pause == PauseEvery || next_pause == 3 * PauseEvery) hold_req = 1'b1;
        else wait_drained();
        next_pause += PauseEvery;
      end
    end
    send_length(clre_pkg::LEN_W'($urandom), 1'b1);
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("[code_length_run_encoder_core] OK");
    end else begin
      $display("[code_length_run_encoder_core] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/clre_pkg.sv
src/code_length_run_encoder_core.sv
bench/clre_run_checker.sv
bench/tb_code_length_run_encoder_core.sv
